// File: design/epwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwd_pkg: shared types and constants of the wake word detector
// Profile table, register indexes, reset values, the cell bus type.
// ----------------------------------------------------------------------------
package epwd_pkg;

    localparam int FRAME_SIZE_DEF      = 32;
    localparam int WINDOW_FRAMES       = 16;
    localparam int COOLDOWN_FRAMES_DEF = 256;
    localparam int WORD_COUNT_DEF      = 5;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOICED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_BASE    = 3'd3;

    localparam logic [15:0] NOISE_FLOOR_RST = 16'd200;
    localparam logic [2:0]  WORDS_EN_RST    = 3'd5;
    localparam logic [4:0]  MIN_VOICED_RST  = 5'd4;

    // window data handed from cell to cell
    typedef struct packed {
        logic [15:0] energy;
        logic        voiced;
    } hist_t;

    function automatic logic [9:0] thr_reset(input logic [2:0] w);
        logic [9:0] r;
        begin
            case (w)
                3'd0: r = 10'd480;
                3'd1: r = 10'd450;
                3'd2: r = 10'd440;
                3'd3: r = 10'd420;
                default: r = 10'd430;
            endcase
            return r;
        end
    endfunction

    // built-in profiles, entry k is matched against the k-th oldest frame
    function automatic logic [15:0] profile(input logic [2:0] w, input logic [3:0] k);
        logic [15:0] t [0:15];
        begin
            case (w)
                3'd0: t = '{16'd100, 16'd800, 16'd3200, 16'd6400, 16'd9800, 16'd14000,
                            16'd12000, 16'd8000, 16'd10000, 16'd15000, 16'd12000,
                            16'd7000, 16'd3000, 16'd1200, 16'd400, 16'd100};
                3'd1: t = '{16'd300, 16'd4000, 16'd12000, 16'd18000, 16'd16000, 16'd8000,
                            16'd2000, 16'd800, 16'd1500, 16'd9000, 16'd16000,
                            16'd13000, 16'd8000, 16'd3500, 16'd900, 16'd200};
                3'd2: t = '{16'd200, 16'd3000, 16'd10000, 16'd16000, 16'd14000, 16'd9000,
                            16'd4000, 16'd1500, 16'd500, 16'd800, 16'd9000,
                            16'd14000, 16'd11000, 16'd6000, 16'd2000, 16'd400};
                3'd3: t = '{16'd400, 16'd5000, 16'd14000, 16'd18000, 16'd16000, 16'd14000,
                            16'd12000, 16'd10000, 16'd10000, 16'd12000, 16'd14000,
                            16'd12000, 16'd8000, 16'd4000, 16'd1500, 16'd300};
                default: t = '{16'd300, 16'd3500, 16'd11000, 16'd16000, 16'd12000, 16'd6000,
                            16'd1500, 16'd300, 16'd200, 16'd1200, 16'd8000,
                            16'd13000, 16'd10000, 16'd5000, 16'd1800, 16'd400};
            endcase
            return t[k];
        end
    endfunction

endpackage
`default_nettype wire

// File: design/epwd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwd_cell: one window cell
// Holds one frame energy and voiced flag; shifts in on a new frame and
// rotates around the ring during scoring.
// ----------------------------------------------------------------------------
module epwd_cell (
    input  wire             clk,
    input  wire             shift_en,
    input  epwd_pkg::hist_t din,
    output epwd_pkg::hist_t dout
);
    import epwd_pkg::*;

    hist_t data_reg;

    // take the neighbor's value on each shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;
endmodule
`default_nettype wire

// File: design/epwd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epwd_sqrt: iterative floor square root
// One result bit per cycle, a 16-bit root from a 32-bit operand.
// ----------------------------------------------------------------------------
module epwd_sqrt (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);
    logic [31:0] rem_reg;
    logic [15:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] bitv;
    logic [33:0] cand;

    assign bitv  = 32'd1 << {cnt_reg[3:0], 1'b0};

    // restoring root, MSB first: test (2*root+1)<<2k
    assign cand = ({18'd0, root_reg} << ({1'b0, cnt_reg[3:0]} + 5'd1))
                  + {2'd0, bitv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd15;
                rem_reg  <= radicand;
                root_reg <= 16'd0;
            end
            else if (busy_reg)
            begin
                if ({2'd0, rem_reg} >= cand)
                begin
                    rem_reg  <= rem_reg - cand[31:0];
                    root_reg[cnt_reg[3:0]] <= 1'b1;
                end
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    assign root = root_reg;
endmodule
`default_nettype wire

// File: design/energy_profile_wake_word_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// energy_profile_wake_word_detector: frame energy and profile matching
// Accumulates PCM frames, finds twice their RMS level, keeps a 16-frame ring
// of cells and scores the built-in word profiles at voiced frames outside cooldown.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | beat
//  in       | in_valid, in_stall, action, sample      | one sample or soft reset
//  out      | out_valid, out_stall, frame_energy ...  | one result per frame
//  cfg      | cfg_we, cfg_index, cfg_data             | one register write
// A sample that does not end a frame only updates the sums and counts. A frame
// end waits on the square root loop, then scores each profile with one ring
// rotation through the cell chain and a compare.
// in_stall is high while a frame is processed; the output state of a frame end
// holds while the previous result still waits at the output.
// Reset clears control state.
// ----------------------------------------------------------------------------
module energy_profile_wake_word_detector #(
    parameter int COOLDOWN_FRAMES = epwd_pkg::COOLDOWN_FRAMES_DEF,
    parameter int WORD_COUNT      = epwd_pkg::WORD_COUNT_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               action,
    input  wire signed [15:0]                 sample,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [15:0]                       frame_energy,
    output logic [7:0]                        crossing_rate,
    output logic                              voiced,
    output logic                              detected,
    output logic [2:0]                        word_index,
    input  wire                               cfg_we,
    input  wire  [epwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [epwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import epwd_pkg::*;

    // frame length must be a power of two: mean and rate use shifts
    localparam int FRAME_SIZE = FRAME_SIZE_DEF;
    localparam int CNT_W  = $clog2(FRAME_SIZE + 1);
    localparam int CRS_W  = $clog2(FRAME_SIZE);
    localparam int SUM_W  = 30 + $clog2(FRAME_SIZE + 1);
    localparam int SH     = $clog2(FRAME_SIZE);
    localparam int RATE_W = CRS_W + 8;

    typedef enum logic [2:0] {S_ACC, S_SQRT, S_WAIT, S_PREP, S_SCORE, S_EVAL, S_OUT}
        state_t;

    // configuration registers
    logic [15:0] bg_level_reg;
    logic [2:0]  words_en_reg;
    logic [4:0]  voiced_need_reg;
    logic [9:0]  thr_reg [0:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_level_reg    <= NOISE_FLOOR_RST;
            words_en_reg    <= WORDS_EN_RST;
            voiced_need_reg <= MIN_VOICED_RST;
            for (int i = 0; i < 5; i++)
            begin
                thr_reg[i] <= thr_reset(3'(i));
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NOISE_FLOOR: bg_level_reg    <= cfg_data;
                REG_WORDS_EN:    words_en_reg    <= cfg_data[2:0];
                REG_MIN_VOICED:  voiced_need_reg <= cfg_data[4:0];
                default:         thr_reg[cfg_index - REG_THR_BASE] <= cfg_data[9:0];
            endcase
        end
    end

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CRS_W:0]   cross_reg;
    logic             prev_reg;
    logic [4:0]       seen_reg;
    logic [11:0]      cool_reg;
    logic [2:0]       word_reg;
    logic [3:0]       k_reg;
    logic [19:0]      dist_reg;
    logic [4:0]       vcnt_reg;
    logic [15:0]      energy_reg;
    logic             voiced_reg;
    logic [2:0]       limit_reg;
    logic [7:0]       rate_reg;
    logic             det_reg;
    logic [2:0]       widx_reg;

    logic               accept;
    logic               out_free;
    logic               sq_start, sq_done;
    logic [15:0]        sq_root;
    logic [31:0]        mean;
    logic               nonneg;
    logic signed [31:0] samp_ext;
    logic [31:0]        sq;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;
    assign nonneg   = !sample[15];
    assign samp_ext = 32'(sample);
    assign sq       = samp_ext * samp_ext;
    assign mean     = 32'(sum_reg >> SH);
    assign sq_start = (state_reg == S_SQRT);

    epwd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (mean),
        .done     (sq_done),
        .root     (sq_root)
    );

    // ring of cells: cell 0 is newest, cell 15 oldest
    hist_t ring_d [0:WINDOW_FRAMES-1];
    hist_t ring_q [0:WINDOW_FRAMES-1];
    logic  shift_en;
    logic  push;
    hist_t new_h;

    assign push     = (state_reg == S_PREP);
    assign shift_en = push || (state_reg == S_SCORE);
    assign new_h.energy = energy_reg;
    assign new_h.voiced = voiced_reg;

    // on push take the new frame, while scoring rotate oldest to newest
    always_comb
    begin
        ring_d[0] = push ? new_h : ring_q[WINDOW_FRAMES-1];
        for (int i = 1; i < WINDOW_FRAMES; i++)
        begin
            ring_d[i] = ring_q[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW_FRAMES; g++)
    begin : g_cell
        epwd_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .din      (ring_d[g]),
            .dout     (ring_q[g])
        );
    end

    // distance step on the oldest cell
    logic [15:0] prof, eo, ad;
    assign eo   = ring_q[WINDOW_FRAMES-1].energy;
    assign prof = profile(word_reg, k_reg);
    assign ad   = (eo >= prof) ? eo - prof : prof - eo;

    logic [15:0] avg;
    logic [25:0] pen_mul;
    logic [10:0] pen;
    assign avg     = dist_reg[19:4];
    assign pen_mul = 26'(avg) * 26'd1000;
    assign pen     = 11'(pen_mul >> 15);

    logic [9:0] score;
    assign score = (pen >= 11'd1000) ? 10'd0 : 10'(11'd1000 - pen);

    logic [15:0] thr3;
    assign thr3 = 16'(bg_level_reg * 16'd3);

    logic [RATE_W-1:0] rate_full;
    assign rate_full = RATE_W'(cross_reg) * RATE_W'(255);

    assign in_stall = (state_reg != S_ACC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            cross_reg <= '0;
            prev_reg  <= 1'b0;
            seen_reg  <= 5'd0;
            cool_reg  <= 12'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            // raise on a loaded result, drop once the beat is taken
            if (state_reg == S_OUT && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_ACC:
                begin
                    if (accept)
                    begin
                        if (action)
                        begin
                            cool_reg <= 12'd0;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + SUM_W'(sq);
                            if (cnt_reg != '0 && nonneg != prev_reg)
                            begin
                                cross_reg <= cross_reg + 1'b1;
                            end
                            prev_reg <= nonneg;
                            cnt_reg  <= cnt_reg + 1'b1;
                            if (cnt_reg == CNT_W'(FRAME_SIZE - 1))
                            begin
                                state_reg <= S_SQRT;
                            end
                        end
                    end
                end
                S_SQRT: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (sq_done)
                    begin
                        energy_reg <= sq_root[15] ? 16'hFFFF : {sq_root[14:0], 1'b0};
                        voiced_reg <= (sq_root[15] ? 16'hFFFF : {sq_root[14:0], 1'b0})
                                      > thr3;
                        state_reg  <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    rate_reg  <= 8'(rate_full >> SH);
                    det_reg   <= 1'b0;
                    widx_reg  <= 3'd0;
                    cnt_reg   <= '0;
                    sum_reg   <= '0;
                    cross_reg <= '0;
                    prev_reg  <= 1'b0;
                    if (seen_reg < 5'd16)
                    begin
                        seen_reg <= seen_reg + 5'd1;
                    end
                    limit_reg <= (words_en_reg > 3'(WORD_COUNT)) ? 3'(WORD_COUNT)
                                                                : words_en_reg;
                    word_reg <= 3'd0;
                    k_reg    <= 4'd0;
                    dist_reg <= 20'd0;
                    vcnt_reg <= 5'd0;
                    if (cool_reg != 12'd0)
                    begin
                        cool_reg  <= cool_reg - 12'd1;
                        state_reg <= S_OUT;
                    end
                    else if ((seen_reg >= 5'd15) && voiced_reg
                             && words_en_reg != 3'd0)
                    begin
                        state_reg <= S_SCORE;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCORE:
                begin
                    dist_reg <= dist_reg + 20'(ad);
                    vcnt_reg <= vcnt_reg + 5'(ring_q[WINDOW_FRAMES-1].voiced);
                    k_reg    <= k_reg + 4'd1;
                    if (k_reg == 4'd15)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (vcnt_reg >= voiced_need_reg && score >= thr_reg[word_reg])
                    begin
                        det_reg   <= 1'b1;
                        widx_reg  <= word_reg;
                        cool_reg  <= 12'(COOLDOWN_FRAMES);
                        state_reg <= S_OUT;
                    end
                    else if (word_reg + 3'd1 >= limit_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        word_reg  <= word_reg + 3'd1;
                        k_reg     <= 4'd0;
                        dist_reg  <= 20'd0;
                        vcnt_reg  <= 5'd0;
                        state_reg <= S_SCORE;
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free, then load it
                    if (out_free)
                    begin
                        frame_energy  <= energy_reg;
                        voiced        <= voiced_reg;
                        crossing_rate <= rate_reg;
                        detected      <= det_reg;
                        word_index    <= widx_reg;
                        state_reg     <= S_ACC;
                    end
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/energy_profile_wake_word_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_profile_wake_word_detector_test: self-checking bench of the detector
// Drives PCM samples and soft resets under bursty input and a stalling
// receiver, predicts each frame result in a scoreboard class and compares
// every field. Register settings change between phases while the block idles.
// ----------------------------------------------------------------------------
module energy_profile_wake_word_detector_test;
    import epwd_pkg::*;

    localparam int FRAME_LEN    = FRAME_SIZE_DEF;
    localparam int COOLDOWN_LEN = COOLDOWN_FRAMES_DEF;
    localparam int PROFILE_NUM  = WORD_COUNT_DEF;
    localparam bit ACT_SAMPLE = 1'b0;
    localparam bit ACT_CLEAR  = 1'b1;

    localparam bit [15:0] WORD_SHAPE [5][16] = '{
        '{100, 800, 3200, 6400, 9800, 14000, 12000, 8000,
          10000, 15000, 12000, 7000, 3000, 1200, 400, 100},
        '{300, 4000, 12000, 18000, 16000, 8000, 2000, 800,
          1500, 9000, 16000, 13000, 8000, 3500, 900, 200},
        '{200, 3000, 10000, 16000, 14000, 9000, 4000, 1500,
          500, 800, 9000, 14000, 11000, 6000, 2000, 400},
        '{400, 5000, 14000, 18000, 16000, 14000, 12000, 10000,
          10000, 12000, 14000, 12000, 8000, 4000, 1500, 300},
        '{300, 3500, 11000, 16000, 12000, 6000, 1500, 300,
          200, 1200, 8000, 13000, 10000, 5000, 1800, 400}
    };

    typedef struct {
        bit [15:0] energy;
        bit [7:0]  rate;
        bit        voiced;
        bit        detected;
        bit [2:0]  word;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Frame scoreboard: tracks detector state and queues expected frames
    // ------------------------------------------------------------------------
    class FrameScoreboard;
        bit [15:0] floor_level;
        bit [2:0]  words_en;
        bit [4:0]  voiced_need;
        bit [9:0]  threshold [5];
        int unsigned fill;
        longint unsigned power_sum;
        int unsigned crossings;
        bit prev_nonneg;
        bit [15:0] energy_ring [16];
        bit voiced_ring [16];
        int unsigned ring_pos;
        int unsigned frames_seen;
        int unsigned cooldown;
        frame_result_t pending [$];
        int errors;
        int frames_checked;
        int detections;
        int clears;

        function new();
            floor_level = NOISE_FLOOR_RST;
            words_en    = WORDS_EN_RST;
            voiced_need = MIN_VOICED_RST;
            threshold   = '{480, 450, 440, 420, 430};
            fill = 0; power_sum = 0; crossings = 0; prev_nonneg = 0;
            ring_pos = 0; frames_seen = 0; cooldown = 0;
            errors = 0; frames_checked = 0; detections = 0; clears = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] data);
            if (idx == REG_NOISE_FLOOR)
                floor_level = data;
            else if (idx == REG_WORDS_EN)
                words_en = data[2:0];
            else if (idx == REG_MIN_VOICED)
                voiced_need = data[4:0];
            else
                threshold[idx - REG_THR_BASE] = data[9:0];
        endfunction

        function int unsigned floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= root + b)
                begin
                    n -= root + b;
                    root = (root >> 1) + b;
                end
                else
                    root >>= 1;
                b >>= 2;
            end
            return int'(root);
        endfunction

        // note one accepted beat and queue a frame result when it ends a frame
        function void note_beat(bit act, bit signed [15:0] pcm);
            frame_result_t r;
            int unsigned root, limit, enabled, abs_sum, vcount, idx, penalty;
            int score;
            bit nonneg;
            if (act == ACT_CLEAR)
            begin
                cooldown = 0;
                clears++;
                return;
            end
            nonneg = (pcm >= 0);
            power_sum += longint'(pcm) * longint'(pcm);
            if (fill != 0 && nonneg != prev_nonneg)
                crossings++;
            prev_nonneg = nonneg;
            fill++;
            if (fill < FRAME_LEN)
                return;

            root = floor_root(power_sum / FRAME_LEN);
            r.energy = (root > 32767) ? 16'hFFFF : 16'(root * 2);
            r.rate = 8'((crossings * 255) / FRAME_LEN);
            limit = (32'(floor_level) * 3) & 32'hFFFF;
            r.voiced = (r.energy > limit);
            r.detected = 0;
            r.word = 0;
            fill = 0; power_sum = 0; crossings = 0; prev_nonneg = 0;

            energy_ring[ring_pos] = r.energy;
            voiced_ring[ring_pos] = r.voiced;
            ring_pos = (ring_pos + 1) % 16;
            if (frames_seen < 16)
                frames_seen++;

            // count down the cooldown, else score the enabled profiles in order
            if (cooldown > 0)
                cooldown--;
            else if (frames_seen >= 16 && r.voiced)
            begin
                enabled = (words_en > PROFILE_NUM) ? PROFILE_NUM : words_en;
                for (int w = 0; w < enabled; w++)
                begin
                    abs_sum = 0;
                    vcount = 0;
                    for (int k = 0; k < 16; k++)
                    begin
                        idx = (ring_pos + k) % 16;
                        if (energy_ring[idx] >= WORD_SHAPE[w][k])
                            abs_sum += energy_ring[idx] - WORD_SHAPE[w][k];
                        else
                            abs_sum += WORD_SHAPE[w][k] - energy_ring[idx];
                        vcount += voiced_ring[idx];
                    end
                    penalty = ((abs_sum / 16) * 1000) / 32768;
                    score = 1000 - int'(penalty);
                    if (score < 0)
                        score = 0;
                    if (vcount >= voiced_need && score >= threshold[w])
                    begin
                        r.detected = 1;
                        r.word = 3'(w);
                        cooldown = COOLDOWN_LEN & 12'hFFF;
                        break;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // compare one accepted result beat with the oldest expected frame
        function void check_frame(frame_result_t got);
            frame_result_t want;
            if (pending.size() == 0)
            begin
                $error("result beat with no frame expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            frames_checked++;
            if (want.detected)
                detections++;
            if (got.energy !== want.energy)
            begin
                $error("frame_energy: expected %0d, got %0d", want.energy, got.energy);
                errors++;
            end
            if (got.rate !== want.rate)
            begin
                $error("crossing_rate: expected %0d, got %0d", want.rate, got.rate);
                errors++;
            end
            if (got.voiced !== want.voiced)
            begin
                $error("voiced: expected %0d, got %0d", want.voiced, got.voiced);
                errors++;
            end
            if (got.detected !== want.detected)
            begin
                $error("detected: expected %0d, got %0d", want.detected, got.detected);
                errors++;
            end
            if (got.word !== want.word)
            begin
                $error("word_index: expected %0d, got %0d", want.word, got.word);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic action;
    logic signed [15:0] sample;
    logic out_valid;
    logic out_stall;
    logic [15:0] frame_energy;
    logic [7:0] crossing_rate;
    logic voiced;
    logic detected;
    logic [2:0] word_index;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    FrameScoreboard board;
    int beats_sent;
    int burst_left;
    bit hold_request;

    energy_profile_wake_word_detector i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .frame_energy(frame_energy), .crossing_rate(crossing_rate),
        .voiced(voiced), .detected(detected), .word_index(word_index),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = 1;
            #4 clk = 0;
        end
    end

    // hard stop for a hung run
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check accepted beats, stall in stretches of varying density
    // ------------------------------------------------------------------------
    initial
    begin
        frame_result_t got;
        int mode;
        int mode_left;
        int hold_left;
        out_stall = 0;
        mode = 0;
        mode_left = 100;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.energy = frame_energy;
                got.rate = crossing_rate;
                got.voiced = voiced;
                got.detected = detected;
                got.word = word_index;
                board.check_frame(got);
            end
            if (hold_request && hold_left == 0)
                hold_left = 800;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    hold_request <= 0;
                out_stall <= 1;
            end
            else if (mode == 0)
                out_stall <= 0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 9) < 7);
        end
    end

    // offer one beat, hold it until accepted, then maybe open a gap
    task automatic send_beat(bit act, bit signed [15:0] pcm);
        in_valid <= 1;
        action <= act;
        sample <= pcm;
        do @(posedge clk); while (in_stall);
        board.note_beat(act, pcm);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
    endtask

    // drive one write; the caller drops the enable after the last one
    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] data);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // hold input off until every frame is back, then let the block settle
    task automatic drain_results();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic load_setting(bit [15:0] nf, bit [2:0] we, bit [4:0] mv,
                                int thr_lo, int thr_hi);
        write_reg(REG_NOISE_FLOOR, nf);
        write_reg(REG_WORDS_EN, 16'(we));
        write_reg(REG_MIN_VOICED, 16'(mv));
        for (int w = 0; w < PROFILE_NUM; w++)
            write_reg(REG_THR_BASE + 3'(w), 16'($urandom_range(thr_lo, thr_hi)));
        cfg_we <= 0;
    endtask

    // one frame of a square-ish wave whose energy lands near the target
    task automatic send_shaped_frame(int target);
        int amp;
        bit neg;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            amp = target / 2 + $signed($urandom_range(0, 40)) - 20;
            if (amp < 0)
                amp = 0;
            if (amp > 32767)
                amp = 32767;
            neg = ($urandom_range(0, 2) == 0) ? ~neg : neg;
            send_beat(ACT_SAMPLE, neg ? -16'(amp) : 16'(amp));
        end
    endtask

    // half word-shaped runs, else noise, silence, extremes, short runs, clears
    task automatic run_traffic(int budget);
        int stop_at;
        int pick;
        int w;
        int scale;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                w = $urandom_range(0, PROFILE_NUM - 1);
                scale = $urandom_range(40, 250);
                for (int k = $urandom_range(0, 8); k < 16; k++)
                    send_shaped_frame(WORD_SHAPE[w][k] * scale / 100);
            end
            else if (pick < 65)
                repeat (FRAME_LEN) send_beat(ACT_SAMPLE, 16'($urandom));
            else if (pick < 73)
                repeat (FRAME_LEN) send_beat(ACT_SAMPLE, 16'($urandom_range(0, 6)) - 16'sd3);
            else if (pick < 79)
                repeat (FRAME_LEN)
                    send_beat(ACT_SAMPLE, $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF);
            else if (pick < 92)
                send_beat(ACT_CLEAR, 16'($urandom));
            else
                repeat ($urandom_range(1, 40)) send_beat(ACT_SAMPLE, 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        rst_n = 0;
        in_valid = 0;
        action = 0;
        sample = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        beats_sent = 0;
        burst_left = 20;
        hold_request = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: sample extremes, clears mid-frame, first-sample crossing
        send_beat(ACT_CLEAR, 16'sh0000);
        send_beat(ACT_SAMPLE, 16'sh8000);
        send_beat(ACT_SAMPLE, 16'sh7FFF);
        send_beat(ACT_SAMPLE, 16'sh0000);
        send_beat(ACT_SAMPLE, 16'shFFFF);
        send_beat(ACT_SAMPLE, 16'sh0001);
        send_beat(ACT_CLEAR, 16'shFFFF);
        send_beat(ACT_SAMPLE, 16'sh5555);
        send_beat(ACT_SAMPLE, 16'shAAAA);
        repeat (23) send_beat(ACT_SAMPLE, 16'sh8000);
        send_beat(ACT_SAMPLE, -16'sd5);
        repeat (31) send_beat(ACT_SAMPLE, 16'sd7);

        // reset settings
        run_traffic(250);
        drain_results();

        // everything passes: zero floor and thresholds, receiver holds off
        load_setting(16'd0, 3'd5, 5'd0, 0, 0);
        hold_request = 1;
        run_traffic(350);
        drain_results();

        // nothing can pass: top floor, high thresholds, min voiced at 16
        load_setting(16'hFFFF, 3'd7, 5'd16, 1000, 1023);
        run_traffic(250);
        drain_results();

        // floor wraps past 16 bits, one word, min voiced out of range
        load_setting(16'd21846, 3'd1, 5'd17, 0, 1000);
        run_traffic(250);
        drain_results();

        // loose match, second long hold
        load_setting(16'd100, 3'd6, 5'd8, 300, 700);
        hold_request = 1;
        run_traffic(350);
        drain_results();

        // random settings
        load_setting(16'($urandom_range(0, 3000)), 3'($urandom_range(0, 7)),
                     5'($urandom_range(0, 16)), 0, 1023);
        run_traffic(300);
        drain_results();

        // reset floor, words disabled, then reset words and min voiced
        load_setting(NOISE_FLOOR_RST, 3'd0, 5'd31, 0, 1023);
        run_traffic(100);
        drain_results();
        load_setting(NOISE_FLOOR_RST, WORDS_EN_RST, MIN_VOICED_RST, 420, 480);
        run_traffic(250);
        drain_results();

        $display("covered %0d beats, %0d soft resets, %0d frames checked",
                 beats_sent, board.clears, board.frames_checked);
        $display("wake words detected: %0d, mismatches: %0d",
                 board.detections, board.errors);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/epwd_pkg.sv
design/epwd_cell.sv
design/epwd_sqrt.sv
design/energy_profile_wake_word_detector.sv
tb/energy_profile_wake_word_detector_test.sv
